// ===== hdl/narma10_pkg.sv =====
package narma10_pkg;

    localparam int DATA_W = 32;
    // p1 + p2 + p3 + c, each a clipped 32-bit value
    localparam int ACC_W  = 34;
    localparam int PC_W   = 3;

    // microprogram steps
    localparam logic [PC_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] ST_MUL_A = 3'd1;
    localparam logic [PC_W-1:0] ST_MUL_B = 3'd2;
    localparam logic [PC_W-1:0] ST_MUL_X = 3'd3;
    localparam logic [PC_W-1:0] ST_MUL_T = 3'd4;
    localparam logic [PC_W-1:0] ST_SUM   = 3'd5;
    localparam logic [PC_W-1:0] ST_MUL_D = 3'd6;
    localparam logic [PC_W-1:0] ST_OUT   = 3'd7;

    // multiplier operand A select
    localparam logic [2:0] ASEL_COEF_A = 3'd0;
    localparam logic [2:0] ASEL_COEF_B = 3'd1;
    localparam logic [2:0] ASEL_X10    = 3'd2;
    localparam logic [2:0] ASEL_T      = 3'd3;
    localparam logic [2:0] ASEL_COEF_D = 3'd4;

    // multiplier operand B select
    localparam logic [1:0] BSEL_YP   = 2'd0;
    localparam logic [1:0] BSEL_X3   = 2'd1;
    localparam logic [1:0] BSEL_HSUM = 2'd2;
    localparam logic [1:0] BSEL_ACC  = 2'd3;

    // destination of the rounded product
    localparam logic [1:0] DST_NONE = 2'd0;
    localparam logic [1:0] DST_ACC  = 2'd1;
    localparam logic [1:0] DST_T    = 2'd2;
    localparam logic [1:0] DST_Y    = 2'd3;

    // jump conditions
    localparam logic [1:0] JMP_NEVER    = 2'd0;
    localparam logic [1:0] JMP_NO_INPUT = 2'd1;
    localparam logic [1:0] JMP_OUT_FULL = 2'd2;

    typedef struct packed {
        logic            mul_en;
        logic [2:0]      a_sel;
        logic [1:0]      b_sel;
        logic [1:0]      dest;
        logic            rnd_wide;
        logic [1:0]      jcond;
        logic [PC_W-1:0] jtarget;
    } uword_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] d;
    } coef_t;

    // control store; each step with a destination rounds the product of the step before it
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w          = '0;
        w.a_sel    = ASEL_COEF_A;
        w.b_sel    = BSEL_YP;
        w.dest     = DST_NONE;
        w.jcond    = JMP_NEVER;
        w.jtarget  = ST_IDLE;
        case (pc)
            ST_IDLE: begin
                w.jcond   = JMP_NO_INPUT;
                w.jtarget = ST_IDLE;
            end
            ST_MUL_A: begin
                w.mul_en = 1'b1;
                w.a_sel  = ASEL_COEF_A;
                w.b_sel  = BSEL_YP;
            end
            ST_MUL_B: begin
                w.mul_en = 1'b1;
                w.a_sel  = ASEL_COEF_B;
                w.b_sel  = BSEL_YP;
                w.dest   = DST_ACC;
            end
            ST_MUL_X: begin
                w.mul_en = 1'b1;
                w.a_sel  = ASEL_X10;
                w.b_sel  = BSEL_X3;
                w.dest   = DST_T;
            end
            ST_MUL_T: begin
                w.mul_en   = 1'b1;
                w.a_sel    = ASEL_T;
                w.b_sel    = BSEL_HSUM;
                w.dest     = DST_ACC;
                w.rnd_wide = 1'b1;
            end
            ST_SUM: begin
                w.dest = DST_ACC;
            end
            ST_MUL_D: begin
                w.mul_en = 1'b1;
                w.a_sel  = ASEL_COEF_D;
                w.b_sel  = BSEL_ACC;
            end
            ST_OUT: begin
                w.dest    = DST_Y;
                w.jcond   = JMP_OUT_FULL;
                w.jtarget = ST_OUT;
            end
            default: begin
                w.jtarget = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/narma10_useq.sv =====
module narma10_useq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  out_full,
    output narma10_pkg::uword_t   uw,
    output logic                  idle
);

    logic [narma10_pkg::PC_W-1:0] pc_reg;
    logic [narma10_pkg::PC_W-1:0] pc_next;
    logic                         jump;

    assign uw   = narma10_pkg::ucode(pc_reg);
    assign idle = (pc_reg == narma10_pkg::ST_IDLE);

    always_comb begin
        case (uw.jcond)
            narma10_pkg::JMP_NEVER:    jump = 1'b0;
            narma10_pkg::JMP_NO_INPUT: jump = !in_valid;
            narma10_pkg::JMP_OUT_FULL: jump = out_full;
            default:                   jump = 1'b0;
        endcase
    end

    // last step falls through to idle by wrapping
    assign pc_next = jump ? uw.jtarget : pc_reg + narma10_pkg::PC_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= narma10_pkg::ST_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/narma10_history.sv =====
module narma10_history #(
    parameter int HISTORY_DEPTH = 10,
    parameter int HSUM_W        = 36
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     update,
    input  logic signed [31:0]       x_in,
    input  logic signed [31:0]       y_in,
    output logic signed [31:0]       yp,
    output logic signed [31:0]       x10,
    output logic signed [HSUM_W-1:0] hsum
);

    localparam int WP_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    logic signed [31:0]       dh_reg [HISTORY_DEPTH];
    logic signed [31:0]       oh_reg [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [WP_W-1:0]          wpos_reg;
    logic [WP_W-1:0]          wpos_next;
    logic signed [HSUM_W-1:0] hsum_reg;
    logic signed [HSUM_W-1:0] hsum_next;
    logic signed [31:0]       yp_reg;
    logic signed [31:0]       oh_old;

    // entries not written since the last clear read as zero
    assign oh_old = valid_reg[wpos_reg] ? oh_reg[wpos_reg] : 32'sd0;
    assign x10    = valid_reg[wpos_reg] ? dh_reg[wpos_reg] : 32'sd0;
    assign yp     = yp_reg;
    assign hsum   = hsum_reg;

    assign hsum_next = hsum_reg + HSUM_W'(y_in) - HSUM_W'(oh_old);
    assign wpos_next = (wpos_reg == WP_W'(HISTORY_DEPTH - 1)) ? '0
                                                               : wpos_reg + WP_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            wpos_reg  <= '0;
            hsum_reg  <= '0;
            yp_reg    <= '0;
        end else if (clear) begin
            valid_reg <= '0;
            wpos_reg  <= '0;
            hsum_reg  <= '0;
            yp_reg    <= '0;
        end else if (update) begin
            valid_reg[wpos_reg] <= 1'b1;
            wpos_reg            <= wpos_next;
            hsum_reg            <= hsum_next;
            yp_reg              <= y_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            dh_reg[wpos_reg] <= x_in;
            oh_reg[wpos_reg] <= y_in;
        end
    end

endmodule

// ===== hdl/narma10_datapath.sv =====
module narma10_datapath #(
    parameter int FRAC_BITS = 24,
    parameter int HSUM_W    = 36
) (
    input  logic                     aclk,
    input  narma10_pkg::uword_t      uw,
    input  logic                     accept,
    input  logic signed [31:0]       drive_sample,
    input  narma10_pkg::coef_t       coef,
    input  logic signed [31:0]       yp,
    input  logic signed [31:0]       x10,
    input  logic signed [HSUM_W-1:0] hsum,
    output logic signed [31:0]       rnd_val,
    output logic                     sat_total,
    output logic signed [31:0]       x_hold
);

    localparam int ACC_W = narma10_pkg::ACC_W;
    localparam int B_W   = (HSUM_W > ACC_W) ? HSUM_W : ACC_W;
    localparam int PW    = 32 + B_W;

    localparam logic signed [PW-1:0] RMAX   = PW'(32'sh7FFF_FFFF);
    localparam logic signed [PW-1:0] RMIN   = PW'(32'sh8000_0000);
    localparam logic signed [PW-1:0] HALF_N = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HALF_W = PW'(1) <<< FRAC_BITS;

    logic signed [31:0]      x_reg;
    logic signed [ACC_W-1:0] x3_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      t_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    sat_reg;

    logic signed [31:0]      a_op;
    logic signed [B_W-1:0]   b_op;
    logic signed [PW-1:0]    prod_next;
    logic signed [PW-1:0]    rsum;
    logic signed [PW-1:0]    rsh;
    logic                    rnd_sat;

    always_comb begin
        case (uw.a_sel)
            narma10_pkg::ASEL_COEF_A: a_op = coef.a;
            narma10_pkg::ASEL_COEF_B: a_op = coef.b;
            narma10_pkg::ASEL_X10:    a_op = x10;
            narma10_pkg::ASEL_T:      a_op = t_reg;
            narma10_pkg::ASEL_COEF_D: a_op = coef.d;
            default:                  a_op = coef.a;
        endcase
    end

    always_comb begin
        case (uw.b_sel)
            narma10_pkg::BSEL_YP:   b_op = B_W'(yp);
            narma10_pkg::BSEL_X3:   b_op = B_W'(x3_reg);
            narma10_pkg::BSEL_HSUM: b_op = B_W'(hsum);
            narma10_pkg::BSEL_ACC:  b_op = B_W'(acc_reg);
            default:                b_op = B_W'(yp);
        endcase
    end

    assign prod_next = a_op * b_op;

    // round half away from zero: negative products take one less than half
    assign rsum = prod_reg + (uw.rnd_wide ? HALF_W : HALF_N)
                  - PW'(prod_reg[PW-1]);
    assign rsh  = uw.rnd_wide ? (rsum >>> (FRAC_BITS + 1)) : (rsum >>> FRAC_BITS);

    assign rnd_sat = (rsh > RMAX) || (rsh < RMIN);
    assign rnd_val = !rnd_sat ? rsh[31:0]
                   : (rsh[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign sat_total = sat_reg | rnd_sat;
    assign x_hold    = x_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= drive_sample;
            x3_reg  <= ACC_W'(drive_sample) + (ACC_W'(drive_sample) <<< 1);
            acc_reg <= ACC_W'(coef.c);
            sat_reg <= 1'b0;
        end else begin
            if (uw.dest == narma10_pkg::DST_ACC) begin
                acc_reg <= acc_reg + ACC_W'(rnd_val);
            end
            if (uw.dest == narma10_pkg::DST_T) begin
                t_reg <= rnd_val;
            end
            if (uw.dest == narma10_pkg::DST_ACC || uw.dest == narma10_pkg::DST_T) begin
                sat_reg <= sat_total;
            end
        end
        if (uw.mul_en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== hdl/narma10_sequence_generator.sv =====
// Channel  Ports                                        Direction
// -------  -------------------------------------------  ---------
// input    s_valid s_ready s_drive_sample s_start_sequence  in
// result   m_valid m_ready m_target_value m_saturated        out
// config   psel penable pwrite paddr pwdata prdata pready    APB
//
// Each item runs an idle step plus seven microcode steps around one shared 32x36
// multiplier with a registered product.
// The result sits in an output register; the input side takes the next item while it
// waits. The last step stalls only while that register is still full.
// Reset (synchronous, active low) clears both histories and loads the default
// coefficients.
module narma10_sequence_generator #(
    parameter int HISTORY_DEPTH = 10,
    parameter int FRAC_BITS     = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_drive_sample,
    input  logic               s_start_sequence,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_target_value,
    output logic               m_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int HSUM_W = 32 + $clog2(HISTORY_DEPTH);

    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;
    localparam logic [1:0] REG_COEF_D = 2'd3;

    localparam logic signed [31:0] COEF_A_RST = 32'sd5033165;
    localparam logic signed [31:0] COEF_B_RST = 32'sd838861;
    localparam logic signed [31:0] COEF_C_RST = 32'sd1677722;
    localparam logic signed [31:0] COEF_D_RST = 32'sd16777216;

    narma10_pkg::coef_t       coef_reg;
    narma10_pkg::uword_t      uw;
    logic                     idle;
    logic                     accept;
    logic                     out_full;
    logic                     out_wr;
    logic                     m_valid_reg;
    logic signed [31:0]       target_reg;
    logic                     sat_reg;
    logic signed [31:0]       yp;
    logic signed [31:0]       x10;
    logic signed [HSUM_W-1:0] hsum;
    logic signed [31:0]       rnd_val;
    logic                     sat_total;
    logic signed [31:0]       x_hold;

    assign s_ready  = idle;
    assign accept   = s_valid && idle;
    assign out_full = m_valid_reg && !m_ready;
    assign out_wr   = (uw.dest == narma10_pkg::DST_Y) && !out_full;

    assign m_valid        = m_valid_reg;
    assign m_target_value = target_reg;
    assign m_saturated    = sat_reg;
    assign pready         = 1'b1;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.a <= COEF_A_RST;
            coef_reg.b <= COEF_B_RST;
            coef_reg.c <= COEF_C_RST;
            coef_reg.d <= COEF_D_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_COEF_A: coef_reg.a <= pwdata;
                REG_COEF_B: coef_reg.b <= pwdata;
                REG_COEF_C: coef_reg.c <= pwdata;
                REG_COEF_D: coef_reg.d <= pwdata;
                default:    coef_reg.a <= coef_reg.a;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_COEF_A: prdata = coef_reg.a;
            REG_COEF_B: prdata = coef_reg.b;
            REG_COEF_C: prdata = coef_reg.c;
            REG_COEF_D: prdata = coef_reg.d;
            default:    prdata = '0;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_wr) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_wr) begin
            target_reg <= rnd_val;
            sat_reg    <= sat_total;
        end
    end

    narma10_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_full (out_full),
        .uw       (uw),
        .idle     (idle)
    );

    narma10_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .HSUM_W        (HSUM_W)
    ) u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (accept && s_start_sequence),
        .update  (out_wr),
        .x_in    (x_hold),
        .y_in    (rnd_val),
        .yp      (yp),
        .x10     (x10),
        .hsum    (hsum)
    );

    narma10_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .HSUM_W    (HSUM_W)
    ) u_datapath (
        .aclk         (aclk),
        .uw           (uw),
        .accept       (accept),
        .drive_sample (s_drive_sample),
        .coef         (coef_reg),
        .yp           (yp),
        .x10          (x10),
        .hsum         (hsum),
        .rnd_val      (rnd_val),
        .sat_total    (sat_total),
        .x_hold       (x_hold)
    );

endmodule

// ===== sim/narma10_sequence_generator_tb.sv =====
`timescale 1ns / 100ps

module narma10_sequence_generator_tb;

    localparam int HIST_DEPTH  = 10;
    localparam int FRAC        = 24;
    localparam int STUCK_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;

    localparam int REG_COEF_A = 0;
    localparam int REG_COEF_B = 1;
    localparam int REG_COEF_C = 2;
    localparam int REG_COEF_D = 3;

    localparam logic [31:0] DEF_A = 32'd5033165;
    localparam logic [31:0] DEF_B = 32'd838861;
    localparam logic [31:0] DEF_C = 32'd1677722;
    localparam logic [31:0] DEF_D = 32'd16777216;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] sample;
        logic               start;
    } drive_item_t;

    typedef struct {
        logic signed [31:0] value;
        logic               clipped;
    } level_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_drive_sample = '0;
    logic               s_start_sequence = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_target_value;
    logic               m_saturated;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    narma10_sequence_generator #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .FRAC_BITS    (FRAC)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_drive_sample  (s_drive_sample),
        .s_start_sequence(s_start_sequence),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_target_value  (m_target_value),
        .m_saturated     (m_saturated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic signed [31:0] coef_val[4];
    longint             drive_hist[HIST_DEPTH];
    longint             level_hist[HIST_DEPTH];
    longint             level_sum;
    int                 slot;

    drive_item_t sample_queue[$];
    level_t      level_queue[$];

    int samples_queued = 0;
    int samples_sent   = 0;
    int starts_sent    = 0;
    int levels_checked = 0;
    int clipped_seen   = 0;
    int holds_done     = 0;
    int errors         = 0;
    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int hold_left       = 0;
    int stuck_cycles    = 0;

    // round(p*q / 2^sh), ties away from zero, clipped to signed 32 bits
    function automatic longint scale_round(input longint p, input longint q, input int sh,
                                           inout bit clipped);
        logic [127:0] mag_p;
        logic [127:0] mag_q;
        logic [127:0] scaled;
        bit           neg;
        neg    = (p < 0) != (q < 0);
        mag_p  = (p < 0) ? 128'(-p) : 128'(p);
        mag_q  = (q < 0) ? 128'(-q) : 128'(q);
        scaled = (mag_p * mag_q + (128'd1 << (sh - 1))) >> sh;
        if (scaled > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
            clipped = 1'b1;
            return neg ? SAT_LO : SAT_HI;
        end
        return neg ? -longint'(scaled[63:0]) : longint'(scaled[63:0]);
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < HIST_DEPTH; i++) begin
            drive_hist[i] = 0;
            level_hist[i] = 0;
        end
        level_sum = 0;
        slot      = 0;
    endfunction

    function automatic void predict_level(input logic signed [31:0] x_in, input logic start);
        longint x, yp, x10, p1, t, p2, p3, inner, y;
        bit     clipped;
        int     prev;
        level_t res;
        x       = x_in;
        clipped = 1'b0;
        if (start)
            clear_history();
        prev  = (slot == 0) ? HIST_DEPTH - 1 : slot - 1;
        yp    = level_hist[prev];
        x10   = drive_hist[slot];
        p1    = scale_round(coef_val[REG_COEF_A], yp, FRAC, clipped);
        t     = scale_round(coef_val[REG_COEF_B], yp, FRAC, clipped);
        p2    = scale_round(t, level_sum, FRAC, clipped);
        p3    = scale_round(3 * x, x10, FRAC + 1, clipped);
        inner = p1 + p2 + p3 + longint'(coef_val[REG_COEF_C]);
        y     = scale_round(coef_val[REG_COEF_D], inner, FRAC, clipped);
        level_sum        = level_sum + y - level_hist[slot];
        level_hist[slot] = y;
        drive_hist[slot] = x;
        slot             = (slot + 1 >= HIST_DEPTH) ? 0 : slot + 1;
        res.value   = y[31:0];
        res.clipped = clipped;
        level_queue.push_back(res);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_level(s_drive_sample, s_start_sequence);
                samples_sent++;
                if (s_start_sequence)
                    starts_sent++;
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    drive_item_t it;
                    it = sample_queue.pop_front();
                    s_valid          <= 1'b1;
                    s_drive_sample   <= it.sample;
                    s_start_sequence <= it.start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                levels_checked++;
                if (level_queue.size() == 0) begin
                    $display("%0t: result with nothing expected: value %0d sat %0b",
                             $time, m_target_value, m_saturated);
                    errors++;
                end else begin
                    level_t want;
                    want = level_queue.pop_front();
                    if (want.clipped)
                        clipped_seen++;
                    if (m_target_value !== want.value) begin
                        $display("%0t: target_value expected %0d, got %0d",
                                 $time, want.value, m_target_value);
                        errors++;
                    end
                    if (m_saturated !== want.clipped) begin
                        $display("%0t: saturated expected %0b, got %0b",
                                 $time, want.clipped, m_saturated);
                        errors++;
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (m_valid && m_ready && levels_checked % 400 == 399) begin
                hold_left <= HOLD_CYCLES;
                holds_done++;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_reg(input int idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (pready !== 1'b1) begin
            $display("%0t: pready expected 1, got %0b", $time, pready);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        coef_val[idx] = value;
        // address stays put, so the register reads back on the next edge
        @(posedge aclk);
        if (prdata !== value) begin
            $display("%0t: register %0d read expected %0h, got %0h",
                     $time, idx, value, prdata);
            errors++;
        end
    endtask

    task automatic load_coefs(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        write_reg(REG_COEF_D, d);
    endtask

    task automatic load_moderate_coefs();
        load_coefs($urandom_range(10066330), $urandom_range(3355443) - 32'd1677722,
                   $urandom_range(3355443), $urandom_range(8388608, 25165824));
    endtask

    task automatic push_sample(input logic [31:0] x, input logic start);
        drive_item_t it;
        it.sample = x;
        it.start  = start;
        sample_queue.push_back(it);
        samples_queued++;
    endtask

    // mostly well-formed sequences with inputs in [0, 0.5], some full-range noise
    task automatic queue_sequences(input int count);
        int remaining;
        int run_len;
        remaining = count;
        while (remaining > 0) begin
            run_len = $urandom_range(12, 60);
            for (int k = 0; k < run_len && remaining > 0; k++) begin
                if ($urandom_range(99) < 15)
                    push_sample($urandom, $urandom_range(19) == 0);
                else
                    push_sample($urandom_range(32'h0080_0000), k == 0);
                remaining--;
            end
        end
    endtask

    task automatic wait_drained();
        while (levels_checked != samples_queued)
            @(posedge aclk);
    endtask

    initial begin
        coef_val[REG_COEF_A] = DEF_A;
        coef_val[REG_COEF_B] = DEF_B;
        coef_val[REG_COEF_C] = DEF_C;
        coef_val[REG_COEF_D] = DEF_D;
        clear_history();
        sender_idle_pct = 21;
        recv_idle_pct   = 77;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset coefficients; extremes of x, then the same extremes as x10
        push_sample(Q_MAX, 1'b1);
        push_sample(Q_MIN, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0001, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h0080_0000, 1'b0);
        push_sample(32'h0040_0000, 1'b0);
        push_sample(32'h4000_0000, 1'b0);
        push_sample(32'hC000_0000, 1'b0);
        push_sample(32'h0000_0002, 1'b0);
        push_sample(Q_MAX, 1'b0);
        push_sample(Q_MAX, 1'b0);
        push_sample(Q_MIN, 1'b0);
        push_sample(Q_MIN, 1'b0);
        push_sample(32'h0100_0000, 1'b0);
        push_sample(32'h0080_0000, 1'b0);
        push_sample(32'hFF00_0000, 1'b0);
        push_sample(Q_MAX, 1'b1);
        push_sample(32'h0080_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b1);
        push_sample(32'h0040_0000, 1'b0);
        push_sample(32'h0020_0000, 1'b0);
        wait_drained();

        load_moderate_coefs();
        queue_sequences(400);
        wait_drained();

        sender_idle_pct = 77;
        recv_idle_pct   = 21;
        load_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_sequences(60);
        wait_drained();
        load_coefs(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        queue_sequences(60);
        wait_drained();
        load_coefs('0, '0, '0, '0);
        queue_sequences(40);
        wait_drained();
        load_coefs($urandom, $urandom, $urandom, $urandom);
        queue_sequences(300);
        wait_drained();

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        load_moderate_coefs();
        queue_sequences(500);
        wait_drained();
        load_coefs(DEF_A, DEF_B, DEF_C, DEF_D);
        queue_sequences(100);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (level_queue.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, level_queue.size());
            errors++;
        end
        $display("Sent %0d drive samples (%0d sequence starts) over 8 coefficient settings.",
                 samples_sent, starts_sent);
        $display("Checked %0d outputs, %0d of them clipped; %0d long output stalls; %0d errors.",
                 levels_checked, clipped_seen, holds_done, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
